[design/fpru_pkg.sv]
// ----------------------------------------------------------------------------
// fpru_pkg
// Shared widths, defaults and controller-to-datapath command word for the
// FIFO page replacement unit.
// ----------------------------------------------------------------------------
package fpru_pkg;

   localparam int DEF_MAX_FRAMES = 8;
   localparam int DEF_PAGE_BITS  = 16;

   localparam int PAGE_W  = 16;   // page number port width
   localparam int SLOT_W  = 3;    // reported slot index width
   localparam int TOTAL_W = 32;   // hit/fault total width
   localparam int FC_W    = 4;    // frame_count register width

   localparam logic [FC_W-1:0] FC_RESET = 4'd8;

   // command word from controller to datapath
   typedef struct packed {
      logic latch;    // capture request word
      logic lookup;   // parallel compare, register match result
      logic commit;   // update frames and counters, present result
   } dp_cmd_type;

endpackage

[design/fpru_ctrl.sv]
// ----------------------------------------------------------------------------
// fpru_ctrl
// Sequencer: idle -> lookup -> commit, one request word at a time.
// ----------------------------------------------------------------------------
module fpru_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   output fpru_pkg::dp_cmd_type cmd
);
   import fpru_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_LOOKUP = 2'd1;
   localparam logic [1:0] ST_COMMIT = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) state_in = ST_LOOKUP;
         end
         ST_LOOKUP: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy       = (state_ff != ST_IDLE);
   assign cmd.latch  = start && (state_ff == ST_IDLE);
   assign cmd.lookup = (state_ff == ST_LOOKUP);
   assign cmd.commit = (state_ff == ST_COMMIT);

endmodule

[design/fpru_datapath.sv]
// ----------------------------------------------------------------------------
// fpru_datapath
// Frame table, parallel compare, ring pointer, saturating totals and the
// result register.
// ----------------------------------------------------------------------------
module fpru_datapath #(
   parameter int MAX_FRAMES = fpru_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = fpru_pkg::DEF_PAGE_BITS
) (
   input  logic                           clock,
   input  logic                           reset,
   input  fpru_pkg::dp_cmd_type           cmd,
   input  logic                           csr_we,
   input  logic [fpru_pkg::FC_W-1:0]      csr_frame_count,
   input  logic [fpru_pkg::PAGE_W-1:0]    req_page_number,
   output logic                           rsp_valid,
   output logic                           rsp_hit,
   output logic                           rsp_evicted_valid,
   output logic [fpru_pkg::PAGE_W-1:0]    rsp_evicted_page,
   output logic [fpru_pkg::SLOT_W-1:0]    rsp_slot_index,
   output logic [fpru_pkg::TOTAL_W-1:0]   rsp_hit_total,
   output logic [fpru_pkg::TOTAL_W-1:0]   rsp_fault_total
);
   import fpru_pkg::*;

   localparam int PW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
   localparam int IW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int NW = $clog2(MAX_FRAMES + 1);
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

   // configuration
   logic [FC_W-1:0] frame_count_ff;

   // frame table
   logic [PW-1:0]         frame_page_ff [MAX_FRAMES];
   logic [MAX_FRAMES-1:0] frame_valid_ff;
   logic [IW-1:0]         ring_ff;
   logic [TOTAL_W-1:0]    hits_ff;
   logic [TOTAL_W-1:0]    faults_ff;

   // request and lookup registers
   logic [PW-1:0] page_ff;
   logic          found_ff;
   logic [IW-1:0] slot_ff;
   logic          ev_valid_ff;
   logic [PW-1:0] ev_page_ff;

   // result registers
   logic                rsp_valid_ff;
   logic                rsp_hit_ff;
   logic                rsp_ev_valid_ff;
   logic [PAGE_W-1:0]   rsp_ev_page_ff;
   logic [SLOT_W-1:0]   rsp_slot_ff;

   logic [NW-1:0]         n_in_use;
   logic [7:0]            fc_wide;
   logic [MAX_FRAMES-1:0] match;
   logic                  found_in;
   logic [IW-1:0]         hit_slot;
   logic [IW-1:0]         load_slot;
   logic [IW-1:0]         slot_in;
   logic [NW-1:0]         slot_next;
   logic [IW-1:0]         ring_in;
   logic [PAGE_W+PW-1:0]  ev_page_ext;
   logic [SLOT_W+IW-1:0]  slot_ext;

   // clamp frame_count into 1..MAX_FRAMES
   assign fc_wide = {4'd0, frame_count_ff};
   always_comb begin
      priority if (frame_count_ff == '0) begin
         n_in_use = NW'(1);
      end else if (fc_wide > 8'(MAX_FRAMES)) begin
         n_in_use = NW'(MAX_FRAMES);
      end else begin
         n_in_use = NW'(frame_count_ff);
      end
   end

   // parallel compare over the slots in use; lowest index wins
   always_comb begin
      for (int i = 0; i < MAX_FRAMES; i++) begin
         match[i] = frame_valid_ff[i] && (frame_page_ff[i] == page_ff)
                    && (NW'(i) < n_in_use);
      end
      hit_slot = '0;
      for (int i = MAX_FRAMES - 1; i >= 0; i--) begin
         if (match[i]) hit_slot = IW'(i);
      end
   end

   assign found_in  = |match;
   assign load_slot = (NW'(ring_ff) < n_in_use) ? ring_ff : '0;
   assign slot_in   = found_in ? hit_slot : load_slot;

   assign slot_next = NW'(slot_ff) + NW'(1);
   assign ring_in   = (slot_next >= n_in_use) ? '0 : IW'(slot_next);

   assign ev_page_ext = {{PAGE_W{1'b0}}, ev_page_ff};
   assign slot_ext    = {{SLOT_W{1'b0}}, slot_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_count_ff <= FC_RESET;
         frame_valid_ff <= '0;
         ring_ff        <= '0;
         hits_ff        <= '0;
         faults_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_we) frame_count_ff <= csr_frame_count;
         rsp_valid_ff <= cmd.commit;
         if (cmd.commit) begin
            if (found_ff) begin
               if (hits_ff != TOTAL_MAX) hits_ff <= hits_ff + 1'b1;
            end else begin
               if (faults_ff != TOTAL_MAX) faults_ff <= faults_ff + 1'b1;
               frame_valid_ff[slot_ff] <= 1'b1;
               ring_ff                 <= ring_in;
            end
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (cmd.latch) page_ff <= req_page_number[PW-1:0];
      if (cmd.lookup) begin
         found_ff    <= found_in;
         slot_ff     <= slot_in;
         ev_valid_ff <= !found_in && frame_valid_ff[load_slot];
         ev_page_ff  <= frame_page_ff[load_slot];
      end
      if (cmd.commit) begin
         if (!found_ff) frame_page_ff[slot_ff] <= page_ff;
         rsp_hit_ff      <= found_ff;
         rsp_ev_valid_ff <= ev_valid_ff;
         rsp_ev_page_ff  <= ev_valid_ff ? ev_page_ext[PAGE_W-1:0] : '0;
         rsp_slot_ff     <= slot_ext[SLOT_W-1:0];
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_slot_index    = rsp_slot_ff;
   assign rsp_hit_total     = hits_ff;
   assign rsp_fault_total   = faults_ff;

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> !rsp_evicted_valid)
      else $error("eviction reported on a hit");

   a_evict_page_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> (rsp_evicted_page == '0))
      else $error("evicted page nonzero without eviction");

   a_commit_strobe: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_valid)
      else $error("commit did not produce a result strobe");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_fault_counts: assert property (@(posedge clock) disable iff (reset)
      cmd.commit && !found_ff && (faults_ff != TOTAL_MAX)
      |=> (faults_ff == $past(faults_ff) + 1'b1))
      else $error("fault total did not advance on a fault");

endmodule

[design/fifo_page_replacement_unit.sv]
// Sequence: a word is latched when accepted, compared in the lookup state and committed in the commit state.
// A new word is taken only in idle, once the previous word has committed its frame table update.
// busy is high in the lookup and commit states after acceptance; the strobe is not held off.
// Reset (synchronous, active high): all frames invalid, ring pointer and totals zero,
// frame_count back to 8; a new reference string begins.
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// FIFO page replacement: each page reference is compared against the frames
// in use; faults load the slot at the ring pointer and report the evicted page.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit #(
   parameter int MAX_FRAMES = fpru_pkg::DEF_MAX_FRAMES,
   parameter int PAGE_BITS  = fpru_pkg::DEF_PAGE_BITS
) (
   input  logic                          clock,
   input  logic                          reset,
   // request word
   input  logic                          start,
   output logic                          busy,
   input  logic [fpru_pkg::PAGE_W-1:0]   req_page_number,
   // result word, one-cycle strobe
   output logic                          rsp_valid,
   output logic                          rsp_hit,
   output logic                          rsp_evicted_valid,
   output logic [fpru_pkg::PAGE_W-1:0]   rsp_evicted_page,
   output logic [fpru_pkg::SLOT_W-1:0]   rsp_slot_index,
   output logic [fpru_pkg::TOTAL_W-1:0]  rsp_hit_total,
   output logic [fpru_pkg::TOTAL_W-1:0]  rsp_fault_total,
   // frame_count register write
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [fpru_pkg::FC_W-1:0]     csr_frame_count
);
   import fpru_pkg::*;

   dp_cmd_type cmd;

   // register writes are always accepted; config must only be written while idle, which the block does not enforce
   assign csr_ready = 1'b1;

   // sequencer: idle -> lookup -> commit
   fpru_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .cmd   (cmd)
   );

   // frame table, compare, counters, result register
   fpru_datapath #(
      .MAX_FRAMES (MAX_FRAMES),
      .PAGE_BITS  (PAGE_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .csr_we            (csr_valid && csr_ready),
      .csr_frame_count   (csr_frame_count),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_hit           (rsp_hit),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_slot_index    (rsp_slot_index),
      .rsp_hit_total     (rsp_hit_total),
      .rsp_fault_total   (rsp_fault_total)
   );

endmodule
